FILE: rtl/core/fpa_pkg.sv
// Shared types and constants for the fixed-point ALU.
// No dependencies.
package fpa_pkg;

    localparam int DATA_W       = 32;
    localparam int MODE_W       = 4;
    localparam int FRAC_BITS_DF = 8;

    typedef enum logic [MODE_W-1:0] {
        MODE_ADD = 4'd0,
        MODE_SUB = 4'd1,
        MODE_MUL = 4'd2,
        MODE_DIV = 4'd3,
        MODE_GT  = 4'd4,
        MODE_LT  = 4'd5,
        MODE_LE  = 4'd6,
        MODE_GE  = 4'd7,
        MODE_EQ  = 4'd8,
        MODE_NE  = 4'd9,
        MODE_INC = 4'd10,
        MODE_DEC = 4'd11,
        MODE_MIN = 4'd12,
        MODE_MAX = 4'd13
    } t_mode;

    // Per-beat control and the non-divide result, carried down the pipe.
    typedef struct packed {
        logic              valid;
        logic              is_div;
        logic              is_mul;
        logic              dz;
        logic              neg;
        logic              cmp;
        logic [DATA_W-1:0] val;
    } t_side;

endpackage

FILE: rtl/core/fpa_if.sv
// Valid/ready channel interfaces for the fixed-point ALU.
// Depends on fpa_pkg.
interface fpa_in_if;
    logic                                  valid;
    logic                                  ready;
    logic        [fpa_pkg::MODE_W-1:0]     mode;
    logic signed [fpa_pkg::DATA_W-1:0]     operand_a;
    logic signed [fpa_pkg::DATA_W-1:0]     operand_b;

    modport source (output valid, mode, operand_a, operand_b, input ready);
    modport sink   (input valid, mode, operand_a, operand_b, output ready);
endinterface

interface fpa_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [fpa_pkg::DATA_W-1:0]     result_value;
    logic                                  compare_true;
    logic                                  divide_by_zero;

    modport source (output valid, result_value, compare_true, divide_by_zero,
                    input ready);
    modport sink   (input valid, result_value, compare_true, divide_by_zero,
                    output ready);
endinterface

FILE: rtl/core/fpa_pre.sv
// Front stage: decode, simple ops, compares, full product, divide operand prep.
// Depends on fpa_pkg.
module fpa_pre #(
    parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  logic [fpa_pkg::MODE_W-1:0]          i_mode,
    input  logic signed [fpa_pkg::DATA_W-1:0]   i_a,
    input  logic signed [fpa_pkg::DATA_W-1:0]   i_b,
    output fpa_pkg::t_side                      o_side,
    output logic signed [2*fpa_pkg::DATA_W-1:0] o_prod,
    output logic [fpa_pkg::DATA_W+FRAC_BITS-1:0] o_num,
    output logic [fpa_pkg::DATA_W-1:0]          o_dmag
);
    import fpa_pkg::*;

    localparam int NW = DATA_W + FRAC_BITS;

    t_side                     n_side, r_side;
    logic signed [2*DATA_W-1:0] r_prod;
    logic [NW-1:0]             r_num;
    logic [DATA_W-1:0]         r_dmag;
    logic [DATA_W-1:0]         amag;
    logic                      lt, eq, gt;

    always_comb begin
        lt   = i_a < i_b;
        eq   = i_a == i_b;
        gt   = i_a > i_b;
        amag = i_a[DATA_W-1] ? DATA_W'(-i_a) : DATA_W'(i_a);
        n_side        = '0;
        n_side.valid  = i_valid;
        case (t_mode'(i_mode))
            MODE_ADD: n_side.val = DATA_W'(i_a + i_b);
            MODE_SUB: n_side.val = DATA_W'(i_a - i_b);
            MODE_MUL: n_side.is_mul = 1'b1;
            MODE_DIV: begin
                n_side.is_div = 1'b1;
                n_side.dz     = (i_b == '0);
                n_side.neg    = i_a[DATA_W-1] ^ i_b[DATA_W-1];
            end
            MODE_GT:  n_side.cmp = gt;
            MODE_LT:  n_side.cmp = lt;
            MODE_LE:  n_side.cmp = lt | eq;
            MODE_GE:  n_side.cmp = gt | eq;
            MODE_EQ:  n_side.cmp = eq;
            MODE_NE:  n_side.cmp = ~eq;
            MODE_INC: n_side.val = DATA_W'(i_a + DATA_W'(1));
            MODE_DEC: n_side.val = DATA_W'(i_a - DATA_W'(1));
            MODE_MIN: n_side.val = lt ? i_a : i_b;
            MODE_MAX: n_side.val = gt ? i_a : i_b;
            default:  n_side.val = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side.valid <= 1'b0;
        end else if (i_en) begin
            r_side <= n_side;
            r_prod <= i_a * i_b;
            r_num  <= NW'(amag) << FRAC_BITS;
            r_dmag <= i_b[DATA_W-1] ? DATA_W'(-i_b) : DATA_W'(i_b);
        end
    end

    assign o_side = r_side;
    assign o_prod = r_prod;
    assign o_num  = r_num;
    assign o_dmag = r_dmag;
endmodule

FILE: rtl/core/fpa_div_stage.sv
// One restoring-division step (one quotient bit) with its pipeline register.
// Depends on fpa_pkg.
module fpa_div_stage #(
    parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  fpa_pkg::t_side                       i_side,
    input  logic [fpa_pkg::DATA_W-1:0]           i_rem,
    input  logic [fpa_pkg::DATA_W+FRAC_BITS-1:0] i_nq,
    input  logic [fpa_pkg::DATA_W-1:0]           i_d,
    output fpa_pkg::t_side                       o_side,
    output logic [fpa_pkg::DATA_W-1:0]           o_rem,
    output logic [fpa_pkg::DATA_W+FRAC_BITS-1:0] o_nq,
    output logic [fpa_pkg::DATA_W-1:0]           o_d
);
    import fpa_pkg::*;

    localparam int NW = DATA_W + FRAC_BITS;

    t_side             r_side;
    logic [DATA_W-1:0] r_rem, r_d, n_rem;
    logic [NW-1:0]     r_nq, n_nq;
    logic [DATA_W:0]   trial, diff;
    logic              ge;

    always_comb begin
        trial = {i_rem, i_nq[NW-1]};
        diff  = trial - {1'b0, i_d};
        ge    = trial >= {1'b0, i_d};
        n_rem = ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
        n_nq  = {i_nq[NW-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side.valid <= 1'b0;
        end else if (i_en) begin
            r_side <= i_side;
            r_rem  <= n_rem;
            r_nq   <= n_nq;
            r_d    <= i_d;
        end
    end

    assign o_side = r_side;
    assign o_rem  = r_rem;
    assign o_nq   = r_nq;
    assign o_d    = r_d;
endmodule

FILE: rtl/core/fixed_point_alu_top.sv
// Channel   Dir  Payload
// i_in      in   mode, operand_a, operand_b
// o_out     out  result_value, compare_true, divide_by_zero
// One beat per cycle while o_out is not stalled; Q24.8 with the default FRAC_BITS. The
// divider computes one quotient bit per stage. Every mode takes the same path.
// Synchronous active-low reset clears the valid bits only.
// A stall on o_out freezes the whole pipe; a bubble at the output lets it run.
// Depends on fpa_pkg, fpa_if, fpa_pre, fpa_div_stage.
module fixed_point_alu_top #(
    parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fpa_in_if.sink    i_in,
    fpa_out_if.source o_out
);
    import fpa_pkg::*;

    localparam int NW = DATA_W + FRAC_BITS;

    logic                       en;
    t_side                      s1_side, n_s2_side, r_s2_side, r_out_side;
    logic signed [2*DATA_W-1:0] s1_prod;
    logic [NW-1:0]              s1_num, r_s2_num;
    logic [DATA_W-1:0]          s1_dmag, r_s2_dmag;
    logic signed [2*DATA_W-1:0] prod_sh;
    logic [NW-1:0]              q_signed;
    logic [DATA_W-1:0]          n_val, r_val;

    t_side             d_side [NW+1];
    logic [DATA_W-1:0] d_rem  [NW+1];
    logic [NW-1:0]     d_nq   [NW+1];
    logic [DATA_W-1:0] d_d    [NW+1];

    assign en         = !r_out_side.valid || o_out.ready;
    assign i_in.ready = en;

    fpa_pre #(.FRAC_BITS(FRAC_BITS)) u_pre (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in.valid),
        .i_mode  (i_in.mode),
        .i_a     (i_in.operand_a),
        .i_b     (i_in.operand_b),
        .o_side  (s1_side),
        .o_prod  (s1_prod),
        .o_num   (s1_num),
        .o_dmag  (s1_dmag)
    );

    assign prod_sh = s1_prod >>> FRAC_BITS;

    always_comb begin
        n_s2_side     = s1_side;
        n_s2_side.val = s1_side.is_mul ? prod_sh[DATA_W-1:0] : s1_side.val;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_side.valid <= 1'b0;
        end else if (en) begin
            r_s2_side     <= n_s2_side;
            r_s2_num      <= s1_num;
            r_s2_dmag     <= s1_dmag;
        end
    end

    assign d_side[0] = r_s2_side;
    assign d_rem[0]  = '0;
    assign d_nq[0]   = r_s2_num;
    assign d_d[0]    = r_s2_dmag;

    for (genvar k = 0; k < NW; k++) begin : g_div
        fpa_div_stage #(.FRAC_BITS(FRAC_BITS)) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_side  (d_side[k]),
            .i_rem   (d_rem[k]),
            .i_nq    (d_nq[k]),
            .i_d     (d_d[k]),
            .o_side  (d_side[k+1]),
            .o_rem   (d_rem[k+1]),
            .o_nq    (d_nq[k+1]),
            .o_d     (d_d[k+1])
        );
    end

    always_comb begin
        q_signed = d_side[NW].neg ? NW'(-d_nq[NW]) : d_nq[NW];
        if (!d_side[NW].is_div) begin
            n_val = d_side[NW].val;
        end else if (d_side[NW].dz) begin
            n_val = '0;
        end else begin
            n_val = q_signed[DATA_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_side.valid <= 1'b0;
        end else if (en) begin
            r_out_side <= d_side[NW];
            r_val      <= n_val;
        end
    end

    assign o_out.valid          = r_out_side.valid;
    assign o_out.result_value   = r_val;
    assign o_out.compare_true   = r_out_side.cmp;
    assign o_out.divide_by_zero = r_out_side.dz;

`ifndef NO_ASSERTIONS
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.divide_by_zero |-> o_out.result_value == '0
                                                && !o_out.compare_true)
        else $error("divide by zero beat with non-zero result");

    a_cmp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.compare_true |-> o_out.result_value == '0)
        else $error("compare beat with non-zero value");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(d_side[NW]) && $stable(r_s2_side))
        else $error("pipeline moved during stall");
`endif
endmodule
